// File: sv/parallel_port_handshake_master_core_assert.svh
// assertion macros shared by the rtl
`ifndef PARALLEL_PORT_HANDSHAKE_MASTER_CORE_ASSERT_SVH
`define PARALLEL_PORT_HANDSHAKE_MASTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PPHM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PPHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPHM_ASSERT_NOW(label, ante, cons, msg)
`define PPHM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/pphm_pkg.sv
`timescale 1ns / 1ps

package pphm_pkg;

    // request modes, also the operation kind
    localparam logic [1:0] MODE_PWM    = 2'd0;
    localparam logic [1:0] MODE_ENC    = 2'd1;
    localparam logic [1:0] MODE_INIT   = 2'd2;
    localparam logic [1:0] MODE_SAMPLE = 2'd3;

    localparam logic [8:0]  DUTY_MAX       = 9'd498;
    localparam logic [8:0]  DUTY_MIN       = 9'd2;
    localparam logic [7:0]  CMD_PWM        = 8'h20;
    localparam logic [7:0]  CMD_ENC        = 8'h40;
    localparam logic [23:0] ENC_MUNGE      = 24'h800000;
    localparam logic [7:0]  POLL_LIMIT_RST = 8'd20;
    localparam logic [4:0]  STEP_IDLE      = 5'd0;
    localparam logic [3:0]  HS_TOTAL_PWM   = 4'd6;
    localparam logic [3:0]  HS_TOTAL_ENC   = 4'd10;
    localparam logic [3:0]  HS_TOTAL_INIT  = 4'd8;
    localparam logic [3:0]  ENC_LAST_ROUND = 4'd8;
    localparam logic [3:0]  PWM_SLICES     = 4'd5;

    localparam logic [7:0] INIT_BYTES [8] = '{
        8'h70, 8'h74, 8'h70, 8'h00, 8'h68, 8'h6c, 8'h68, 8'h00
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic        channel;
        logic [15:0] pwm_value;
        logic [7:0]  status_byte;
    } t_req;

    typedef struct packed {
        logic [7:0]  port_byte;
        logic        port_write;
        logic [23:0] encoder_count;
        logic        timed_out;
        logic        done_res;
    } t_result;

    // number of handshakes in an operation
    function automatic logic [3:0] hs_total(input logic [1:0] kind);
        logic [3:0] tot;
        case (kind)
            MODE_PWM: tot = HS_TOTAL_PWM;
            MODE_ENC: tot = HS_TOTAL_ENC;
            default:  tot = HS_TOTAL_INIT;
        endcase
        return tot;
    endfunction

    // data port byte written at the start of handshake k
    function automatic logic [7:0] byte_for(
        input logic [1:0] kind,
        input logic [3:0] k,
        input logic [7:0] base,
        input logic [8:0] duty
    );
        logic [7:0] b;
        logic [1:0] slice;
        case (k[2:0])
            3'd0:    slice = duty[1:0];
            3'd1:    slice = duty[3:2];
            3'd2:    slice = duty[5:4];
            3'd3:    slice = duty[7:6];
            default: slice = {1'b0, duty[8]};
        endcase
        case (kind)
            MODE_PWM: begin
                if (k >= PWM_SLICES) b = 8'h00;
                else b = base | {5'd0, k[0], slice};
            end
            MODE_ENC: begin
                if (k == 4'd0) b = base;
                else if (k > ENC_LAST_ROUND) b = 8'h00;
                else b = base | {5'd0, k[0], 2'b00};
            end
            default: b = INIT_BYTES[k[2:0]];
        endcase
        return b;
    endfunction

endpackage

// File: sv/pphm_req_if.sv
`timescale 1ns / 1ps

interface pphm_req_if;
    import pphm_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        channel;
    logic [15:0] pwm_value;
    logic [7:0]  status_byte;

    modport source (output valid, mode, channel, pwm_value, status_byte, input ready);
    modport sink   (input valid, mode, channel, pwm_value, status_byte, output ready);
endinterface

// File: sv/pphm_res_if.sv
`timescale 1ns / 1ps

interface pphm_res_if;
    import pphm_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  port_byte;
    logic        port_write;
    logic [23:0] encoder_count;
    logic        timed_out;
    logic        done_res;

    modport source (output valid, port_byte, port_write, encoder_count, timed_out, done_res,
                    input ready);
    modport sink   (input valid, port_byte, port_write, encoder_count, timed_out, done_res,
                    output ready);
endinterface

// File: sv/pphm_res_buf.sv
`timescale 1ns / 1ps

module pphm_res_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  pphm_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output pphm_pkg::t_result o_data,
    input  logic              i_ready
);
    import pphm_pkg::*;

    t_result    r_ent [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_pop;
    logic       w_push;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;
    assign w_push  = i_wr && o_ready;

    // two-word result queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop) r_rd_ptr <= ~r_rd_ptr;
            if (w_push && !w_pop) r_cnt <= r_cnt + 2'd1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// File: sv/parallel_port_handshake_master_core.sv
`timescale 1ns / 1ps
// Handshake master for a parallel-port motion card.
// i_req carries words: a pwm write, encoder read or init request, or a
// status port sample (mode 3). Each request starts a fixed run of data
// port writes; every write is followed by polling the sampled status bit 7
// until it leaves its expected level or poll_limit samples pass (timeout).
// o_res carries result words: a byte to drive (port_write), and a final
// word with done_res set, the offset-binary encoder count and the timeout
// flag. A word may produce no result (ignored request, ongoing poll).
// i_cfg_we / i_cfg_wdata write poll_limit; write it only while idle.
// Order: a word is held in the input register, and its result is then written
// into the two-word result queue, which drives o_res.
// Throughput: one word per cycle while the queue has room; each word is
// handled in a single pass between the input register and the queue.
// Reset: sequencer idle, poll_limit 20, input register and queue empty.
// Receiver stall: the queue absorbs two results; then i_req.ready drops
// and the word in the input register holds until space opens.
module parallel_port_handshake_master_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    pphm_req_if.sink   i_req,
    pphm_res_if.source o_res
);
    import pphm_pkg::*;

    `include "parallel_port_handshake_master_core_assert.svh"

    // registers
    logic [7:0]  r_poll_limit;
    logic        r_in_vld;
    t_req        r_in;
    logic [4:0]  r_step,    n_step;
    logic [1:0]  r_kind,    n_kind;
    logic [7:0]  r_base,    n_base;
    logic [8:0]  r_duty,    n_duty;
    logic [7:0]  r_poll,    n_poll;
    logic [23:0] r_accum,   n_accum;
    logic        r_timeout, n_timeout;

    logic        w_proc;
    logic        w_buf_rdy;
    logic        w_res_vld;
    t_result     w_res;
    t_result     w_out;

    // combinational helpers
    logic        w_begin;
    logic        w_finish;
    logic [3:0]  w_k;
    logic [3:0]  w_next;
    logic [7:0]  w_poll_inc;
    logic [15:0] w_pwm;
    logic [8:0]  w_clamp;
    logic [2:0]  w_round;

    assign w_proc      = r_in_vld && w_buf_rdy;
    assign i_req.ready = !r_in_vld || w_proc;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.mode        <= i_req.mode;
            r_in.channel     <= i_req.channel;
            r_in.pwm_value   <= i_req.pwm_value;
            r_in.status_byte <= i_req.status_byte;
        end
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    // duty clamp
    always_comb begin
        w_pwm = r_in.pwm_value;
        if (w_pwm > {7'd0, DUTY_MAX}) w_clamp = DUTY_MAX;
        else if (w_pwm < {7'd0, DUTY_MIN}) w_clamp = DUTY_MIN;
        else w_clamp = w_pwm[8:0];
    end

    // sequencer next state and result
    always_comb begin
        n_step     = r_step;
        n_kind     = r_kind;
        n_base     = r_base;
        n_duty     = r_duty;
        n_poll     = r_poll;
        n_accum    = r_accum;
        n_timeout  = r_timeout;
        w_begin    = 1'b0;
        w_finish   = 1'b0;
        w_k        = r_step[4:1];
        w_next     = w_k + 4'd1;
        w_poll_inc = r_poll + 8'd1;
        w_round    = 3'(w_k - 4'd1);
        w_res_vld  = 1'b0;
        w_res      = '0;

        if (w_proc) begin
            if (r_step == STEP_IDLE) begin
                if (r_in.mode != MODE_SAMPLE) begin
                    // new operation
                    n_kind    = r_in.mode;
                    n_timeout = 1'b0;
                    n_accum   = '0;
                    if (r_in.mode == MODE_PWM) begin
                        n_duty = w_clamp;
                        n_base = CMD_PWM | {2'b00, 2'(r_in.channel) + 2'd1, 4'd0};
                    end else if (r_in.mode == MODE_ENC) begin
                        n_base = CMD_ENC | {2'b00, 2'(r_in.channel) + 2'd1, 4'd0};
                    end
                    w_begin = 1'b1;
                    w_k     = 4'd0;
                end
            end else if (r_in.mode == MODE_SAMPLE) begin
                if (!r_step[0]) begin
                    // encoder slice capture, then the round's handshake
                    n_accum = r_accum
                            | ({21'd0, r_in.status_byte[5:3]} << (5'(w_round) * 5'd3));
                    w_begin = 1'b1;
                end else if (r_in.status_byte[7] != r_step[1]) begin
                    w_finish = 1'b1;
                end else if (w_poll_inc >= r_poll_limit) begin
                    n_timeout = 1'b1;
                    w_finish  = 1'b1;
                end else begin
                    n_poll = w_poll_inc;
                end
            end
        end

        // handshake end
        if (w_finish) begin
            if (w_next >= hs_total(n_kind)) begin
                n_step              = STEP_IDLE;
                n_poll              = 8'd0;
                w_res_vld           = 1'b1;
                w_res.done_res      = 1'b1;
                w_res.encoder_count = (n_kind == MODE_ENC) ? (n_accum ^ ENC_MUNGE) : 24'd0;
            end else if (n_kind == MODE_ENC && w_next <= ENC_LAST_ROUND) begin
                n_step = {w_next, 1'b0};
            end else begin
                w_begin = 1'b1;
                w_k     = w_next;
            end
        end

        // handshake start: write the byte
        if (w_begin) begin
            n_step           = {w_k, 1'b1};
            n_poll           = 8'd0;
            w_res_vld        = 1'b1;
            w_res.port_write = 1'b1;
            w_res.port_byte  = byte_for(n_kind, w_k, n_base, n_duty);
        end
        w_res.timed_out = n_timeout;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_IDLE;
            r_kind    <= MODE_PWM;
            r_base    <= 8'd0;
            r_duty    <= 9'd0;
            r_poll    <= 8'd0;
            r_accum   <= 24'd0;
            r_timeout <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_kind    <= n_kind;
            r_base    <= n_base;
            r_duty    <= n_duty;
            r_poll    <= n_poll;
            r_accum   <= n_accum;
            r_timeout <= n_timeout;
        end
    end

    // result queue
    pphm_res_buf u_res_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_vld),
        .i_data  (w_res),
        .o_ready (w_buf_rdy),
        .o_valid (o_res.valid),
        .o_data  (w_out),
        .i_ready (o_res.ready)
    );

    assign o_res.port_byte     = w_out.port_byte;
    assign o_res.port_write    = w_out.port_write;
    assign o_res.encoder_count = w_out.encoder_count;
    assign o_res.timed_out     = w_out.timed_out;
    assign o_res.done_res      = w_out.done_res;

    // checks
    `PPHM_ASSERT_NOW(a_capture_only_enc, (r_step != STEP_IDLE && !r_step[0]), r_kind == MODE_ENC, "capture step outside encoder read")
    `PPHM_ASSERT_NEXT(a_done_goes_idle, (w_res_vld && w_res.done_res), r_step == STEP_IDLE, "sequencer not idle after final word")
    `PPHM_ASSERT_NOW(a_step_range, r_kind != MODE_ENC, r_step <= 5'd15, "step beyond last handshake")

endmodule

// File: test/tb_parallel_port_handshake_master_core.sv
`timescale 1ns / 1ps

module tb_parallel_port_handshake_master_core;
    import pphm_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    pphm_req_if req_bus ();
    pphm_res_if res_bus ();

    parallel_port_handshake_master_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sequencer mirror
    logic [4:0]  seq_step;
    logic [1:0]  op_kind;
    logic [7:0]  cmd_base;
    logic [8:0]  duty;
    logic        want_level;
    logic [7:0]  polls;
    logic [23:0] enc_accum;
    logic        tmo_seen;
    logic [7:0]  poll_limit;

    t_result     port_results_due [$];
    int unsigned errors;
    int unsigned live_words;
    bit          idle_on;

    // handshakes in the current operation
    function automatic logic [3:0] op_length(input logic [1:0] kind);
        if (kind == MODE_PWM) return HS_TOTAL_PWM;
        if (kind == MODE_ENC) return HS_TOTAL_ENC;
        return HS_TOTAL_INIT;
    endfunction

    // data port byte for handshake k
    function automatic logic [7:0] port_byte_at(input logic [3:0] k);
        logic [8:0] slice_src;
        logic [7:0] b;
        slice_src = duty >> (2 * k);
        if (op_kind == MODE_PWM)
            b = (k >= PWM_SLICES) ? 8'h00 : (cmd_base | {5'd0, k[0], slice_src[1:0]});
        else if (op_kind == MODE_ENC)
            b = (k == 4'd0) ? cmd_base :
                (k > ENC_LAST_ROUND) ? 8'h00 : (cmd_base | {5'd0, k[0], 2'b00});
        else
            b = INIT_BYTES[k[2:0]];
        return b;
    endfunction

    task automatic start_hs(input logic [3:0] k, output t_result r);
        seq_step   = {k, 1'b1};
        want_level = k[0];
        polls      = '0;
        r = '{port_byte: port_byte_at(k), port_write: 1'b1, encoder_count: 24'd0,
              timed_out: tmo_seen, done_res: 1'b0};
    endtask

    task automatic end_hs(input logic [3:0] k, output bit got, output t_result r);
        logic [3:0] nxt;
        nxt = k + 4'd1;
        got = 1'b1;
        r   = '0;
        if (nxt >= op_length(op_kind)) begin
            // closing word of the operation
            seq_step    = STEP_IDLE;
            polls       = '0;
            r.done_res  = 1'b1;
            r.timed_out = tmo_seen;
            if (op_kind == MODE_ENC) r.encoder_count = enc_accum ^ ENC_MUNGE;
        end else if (op_kind == MODE_ENC && nxt <= ENC_LAST_ROUND) begin
            // encoder capture comes before the next write
            seq_step = {nxt, 1'b0};
            got      = 1'b0;
        end else begin
            start_hs(nxt, r);
        end
    endtask

    // apply one accepted word, queue the port result it causes
    task automatic advance_sequencer(input t_req w);
        t_result     r;
        bit          got;
        logic [15:0] clamped;
        logic [3:0]  k;
        logic [2:0]  rnd;
        got = 1'b0;
        r   = '0;
        k   = seq_step[4:1];
        if (seq_step == STEP_IDLE) begin
            if (w.mode != MODE_SAMPLE) begin
                live_words++;
                op_kind   = w.mode;
                tmo_seen  = 1'b0;
                enc_accum = '0;
                clamped   = w.pwm_value;
                if (clamped > 16'(DUTY_MAX)) clamped = 16'(DUTY_MAX);
                if (clamped < 16'(DUTY_MIN)) clamped = 16'(DUTY_MIN);
                if (w.mode == MODE_PWM) begin
                    duty     = clamped[8:0];
                    cmd_base = CMD_PWM | (({7'd0, w.channel} + 8'd1) << 4);
                end else if (w.mode == MODE_ENC) begin
                    cmd_base = CMD_ENC | (({7'd0, w.channel} + 8'd1) << 4);
                end
                start_hs(4'd0, r);
                got = 1'b1;
            end
        end else if (w.mode == MODE_SAMPLE) begin
            live_words++;
            if (!seq_step[0]) begin
                // capture one 3-bit encoder slice
                rnd       = 3'(k - 4'd1);
                enc_accum = enc_accum | (24'(w.status_byte[5:3]) << (3 * rnd));
                start_hs(k, r);
                got = 1'b1;
            end else if (w.status_byte[7] != want_level) begin
                end_hs(k, got, r);
            end else begin
                polls = polls + 8'd1;
                if (polls >= poll_limit) begin
                    tmo_seen = 1'b1;
                    end_hs(k, got, r);
                end
            end
        end
        if (got) port_results_due.push_back(r);
    endtask

    function automatic t_req status_word(input logic [7:0] st);
        t_req w;
        w.mode        = MODE_SAMPLE;
        w.channel     = 1'($urandom);
        w.pwm_value   = 16'($urandom);
        w.status_byte = st;
        return w;
    endfunction

    function automatic t_req request_word(input logic [1:0] m, input logic ch,
                                          input logic [15:0] pwm);
        t_req w;
        w.mode        = m;
        w.channel     = ch;
        w.pwm_value   = pwm;
        w.status_byte = 8'($urandom);
        return w;
    endfunction

    // drive one word, hold it until accepted
    task automatic send_word(input t_req w);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.mode        <= w.mode;
        req_bus.channel     <= w.channel;
        req_bus.pwm_value   <= w.pwm_value;
        req_bus.status_byte <= w.status_byte;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        advance_sequencer(w);
        @(negedge i_clk);
    endtask

    task automatic wait_results_in();
        req_bus.valid <= 1'b0;
        do @(negedge i_clk); while (port_results_due.size() != 0);
    endtask

    // end the running operation with quick level changes
    task automatic finish_operation();
        logic [7:0] st;
        while (seq_step != STEP_IDLE) begin
            st = 8'($urandom);
            if (seq_step[0]) st[7] = ~want_level;
            send_word(status_word(st));
        end
    endtask

    task automatic set_poll_limit(input logic [7:0] v);
        finish_operation();
        wait_results_in();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        poll_limit   = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] pick_duty();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 3));
            2:       return 16'($urandom_range(495, 501));
            default: return 16'($urandom_range(0, 511));
        endcase
    endfunction

    // status samples while idle are dropped
    task automatic test_idle_samples();
        send_word(status_word(8'h00));
        send_word(status_word(8'hff));
    endtask

    // duty saturation at both ends
    task automatic test_pwm_clamp();
        send_word(request_word(MODE_PWM, 1'b0, 16'h0000));
        finish_operation();
        send_word(request_word(MODE_PWM, 1'b1, 16'hffff));
        finish_operation();
    endtask

    // encoder read with all-ones and all-zeros slices
    task automatic test_encoder_read();
        logic [7:0] st;
        send_word(request_word(MODE_ENC, 1'b0, 16'h0000));
        while (seq_step != STEP_IDLE) begin
            st = seq_step[1] ? 8'hff : 8'h00;
            if (seq_step[0]) st[7] = ~want_level;
            send_word(status_word(st));
        end
    endtask

    // init run with requests arriving while busy
    task automatic test_init_busy();
        send_word(request_word(MODE_INIT, 1'b1, 16'hffff));
        send_word(status_word({~want_level, 7'h00}));
        send_word(request_word(MODE_ENC, 1'b1, 16'h1234));
        send_word(request_word(MODE_PWM, 1'b0, 16'h0100));
        finish_operation();
    endtask

    // timeouts at the poll limit extremes
    task automatic test_poll_limit_extremes();
        logic [7:0] st;
        set_poll_limit(8'd255);
        send_word(request_word(MODE_PWM, 1'b1, 16'd300));
        while (seq_step != STEP_IDLE) begin
            st    = 8'($urandom);
            st[7] = (seq_step == 5'd1) ? want_level : ~want_level;
            send_word(status_word(st));
        end
        set_poll_limit(8'd0);
        send_word(request_word(MODE_INIT, 1'b0, 16'd0));
        while (seq_step != STEP_IDLE) begin
            st = 8'($urandom);
            if (seq_step[0]) st[7] = want_level;
            send_word(status_word(st));
        end
        set_poll_limit(8'd1);
        send_word(request_word(MODE_ENC, 1'b1, 16'd0));
        while (seq_step != STEP_IDLE) begin
            st = 8'($urandom);
            if (seq_step[0]) st[7] = want_level;
            send_word(status_word(st));
        end
    endtask

    // mostly complete operations with random content, some noise
    task automatic test_random_traffic(input int unsigned n);
        int unsigned target;
        logic [7:0]  st;
        t_req        w;
        target = live_words + n;
        while (live_words < target) begin
            if (seq_step == STEP_IDLE) begin
                if ($urandom_range(0, 9) == 0)
                    w = status_word(8'($urandom));
                else
                    w = request_word(2'($urandom_range(0, 2)), 1'($urandom), pick_duty());
            end else if ($urandom_range(0, 15) == 0) begin
                w = request_word(2'($urandom_range(0, 2)), 1'($urandom), pick_duty());
            end else begin
                st = 8'($urandom);
                if (seq_step[0] && $urandom_range(0, 2) == 0) st[7] = ~want_level;
                w = status_word(st);
            end
            send_word(w);
        end
    endtask

    // receiver with random stall bursts
    initial begin
        int stall_left;
        stall_left    = 0;
        res_bus.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_port_results
        t_result e;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (port_results_due.size() == 0) begin
                $error("unexpected result word, port_byte %0h done_res %0b",
                       res_bus.port_byte, res_bus.done_res);
                errors++;
            end else begin
                e = port_results_due.pop_front();
                if (res_bus.port_byte !== e.port_byte) begin
                    $error("port_byte: expected %0h, got %0h", e.port_byte, res_bus.port_byte);
                    errors++;
                end
                if (res_bus.port_write !== e.port_write) begin
                    $error("port_write: expected %0b, got %0b", e.port_write,
                           res_bus.port_write);
                    errors++;
                end
                if (res_bus.encoder_count !== e.encoder_count) begin
                    $error("encoder_count: expected %0h, got %0h", e.encoder_count,
                           res_bus.encoder_count);
                    errors++;
                end
                if (res_bus.timed_out !== e.timed_out) begin
                    $error("timed_out: expected %0b, got %0b", e.timed_out, res_bus.timed_out);
                    errors++;
                end
                if (res_bus.done_res !== e.done_res) begin
                    $error("done_res: expected %0b, got %0b", e.done_res, res_bus.done_res);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial begin
        idle_on             = 1'b1;
        errors              = 0;
        live_words          = 0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 8'd0;
        req_bus.valid       = 1'b0;
        req_bus.mode        = MODE_SAMPLE;
        req_bus.channel     = 1'b0;
        req_bus.pwm_value   = 16'd0;
        req_bus.status_byte = 8'd0;
        seq_step            = STEP_IDLE;
        op_kind             = MODE_PWM;
        cmd_base            = '0;
        duty                = '0;
        want_level          = 1'b0;
        polls               = '0;
        enc_accum           = '0;
        tmo_seen            = 1'b0;
        poll_limit          = POLL_LIMIT_RST;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_samples();
        test_pwm_clamp();
        test_encoder_read();
        test_init_busy();
        test_poll_limit_extremes();

        set_poll_limit(8'd3);
        test_random_traffic(300);
        wait_results_in();
        test_random_traffic(150);
        set_poll_limit(8'd0);
        test_random_traffic(200);
        set_poll_limit(8'd7);
        test_random_traffic(300);
        set_poll_limit(8'd255);
        test_random_traffic(150);
        set_poll_limit(8'd1);
        idle_on = 1'b0;
        test_random_traffic(400);
        finish_operation();

        // drain, then let the pipeline settle
        req_bus.valid <= 1'b0;
        for (int n = 0; n < 50000 && port_results_due.size() != 0; n++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (port_results_due.size() != 0) begin
            $error("%0d expected result words never arrived", port_results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("parallel_port_handshake_master_core regression: pass");
        else
            $display("parallel_port_handshake_master_core regression: fail");
        $finish;
    end

    // run guard
    initial begin
        #4_000_000;
        $display("parallel_port_handshake_master_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/pphm_pkg.sv
sv/pphm_req_if.sv
sv/pphm_res_if.sv
sv/pphm_res_buf.sv
sv/parallel_port_handshake_master_core.sv
test/tb_parallel_port_handshake_master_core.sv
